@@ hw/rtl/mlh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlh_pkg: shared types and constants for the link hash block
// Hash constants, datapath op codes, sequencing codes and the microcode ROM.
// ----------------------------------------------------------------------------
package mlh_pkg;

   // hash constants
   localparam logic [63:0] SEED_PRIME = (64'd1 << 44) - 64'd377;
   localparam logic [63:0] CHILD_MULT = 64'd353;
   localparam logic [63:0] MIX_K1     = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] MIX_K2     = 64'hc4ce_b9fe_1a85_ec53;
   localparam int          MIX_SHIFT  = 33;

   // item commands
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_FOLD  = 1'b1;

   // register index, decoded from paddr bit 3
   localparam logic REG_INVALID = 1'b0;

   // datapath operations
   localparam logic [2:0] OP_NOP  = 3'd0;
   localparam logic [2:0] OP_SEED = 3'd1;  // h = type * prime
   localparam logic [2:0] OP_MIX  = 3'd2;  // h = h + ((h << 5) ^ 353 * child)
   localparam logic [2:0] OP_XS   = 3'd3;  // h ^= h >> 33
   localparam logic [2:0] OP_MLO  = 3'd4;  // acc = hL * kL
   localparam logic [2:0] OP_MHA  = 3'd5;  // acc upper += hL * kH
   localparam logic [2:0] OP_MHB  = 3'd6;  // h = acc with upper += hH * kL
   localparam logic [2:0] OP_FIN  = 3'd7;  // load result register

   // sequencing after a step
   localparam logic [1:0] SEQ_NEXT = 2'd0;  // go to next step
   localparam logic [1:0] SEQ_CHK  = 2'd1;  // finish if last, else done
   localparam logic [1:0] SEQ_DONE = 2'd2;  // item done

   // multiplier constant select
   localparam logic KSEL_K1 = 1'b0;
   localparam logic KSEL_K2 = 1'b1;

   // program addresses
   localparam int          STEP_W    = 4;
   localparam logic [3:0]  ADDR_SEED = 4'd0;
   localparam logic [3:0]  ADDR_FOLD = 4'd1;
   localparam logic [3:0]  ADDR_FIN  = 4'd11;

   typedef struct packed {
      logic [2:0] op;
      logic       ksel;
      logic [1:0] seq;
   } uword_type;

   typedef struct packed {
      logic      load;   // capture item fields
      logic      run;    // execute current control word
      uword_type uw;
   } dp_ctl_type;

   // microcode ROM
   function automatic uword_type ucode(input logic [STEP_W-1:0] addr);
      uword_type w;
      unique case (addr)
         4'd0:    w = '{op: OP_SEED, ksel: KSEL_K1, seq: SEQ_CHK};
         4'd1:    w = '{op: OP_MIX,  ksel: KSEL_K1, seq: SEQ_NEXT};
         4'd2:    w = '{op: OP_XS,   ksel: KSEL_K1, seq: SEQ_NEXT};
         4'd3:    w = '{op: OP_MLO,  ksel: KSEL_K1, seq: SEQ_NEXT};
         4'd4:    w = '{op: OP_MHA,  ksel: KSEL_K1, seq: SEQ_NEXT};
         4'd5:    w = '{op: OP_MHB,  ksel: KSEL_K1, seq: SEQ_NEXT};
         4'd6:    w = '{op: OP_XS,   ksel: KSEL_K2, seq: SEQ_NEXT};
         4'd7:    w = '{op: OP_MLO,  ksel: KSEL_K2, seq: SEQ_NEXT};
         4'd8:    w = '{op: OP_MHA,  ksel: KSEL_K2, seq: SEQ_NEXT};
         4'd9:    w = '{op: OP_MHB,  ksel: KSEL_K2, seq: SEQ_NEXT};
         4'd10:   w = '{op: OP_XS,   ksel: KSEL_K2, seq: SEQ_CHK};
         4'd11:   w = '{op: OP_FIN,  ksel: KSEL_K1, seq: SEQ_DONE};
         default: w = '{op: OP_NOP,  ksel: KSEL_K1, seq: SEQ_DONE};
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/merkle_link_hash.sv @@
`timescale 1ns / 1ps
// Only a last item gives a result: a begin item runs the seed step and a fold item the ten
// microcode steps from mix to the final xorshift, each followed by the finish step when last;
// the multiply steps share one 32x32 multiplier. No new item is taken until the sequencer is idle.
// A finished result waits in the output register; a later finish step stalls until it leaves.
// Reset clears the running hash, the sequencer and the output valid, and sets
// the reserved value to all ones.
// ----------------------------------------------------------------------------
// merkle_link_hash: chained 64-bit link content hash
// Microcoded sequencer over a small hash datapath, with an APB register port
// for the reserved hash value.
// ----------------------------------------------------------------------------
module merkle_link_hash (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [15:0] req_atom_type,
   input  logic [63:0] req_child_hash,
   input  logic        req_last,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_link_hash,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import mlh_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_hash_ff, rsp_hash_in;
   logic [63:0]       inv_ff, inv_in;

   logic       accept;
   logic       out_free;
   logic       run;
   uword_type  uw;
   dp_ctl_type dp_ctl;
   logic [63:0] fin_hash;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == REG_INVALID) ? inv_ff : 64'd0;

   always_comb begin
      inv_in = inv_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[3] == REG_INVALID) begin
         inv_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= '1;
      end else begin
         inv_ff <= inv_in;
      end
   end

   // control word fetch and step gating
   assign uw       = ucode(step_ff);
   assign accept   = req_valid && !busy_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign run      = busy_ff && (uw.op != OP_FIN || out_free);
   assign req_stall = busy_ff;

   // sequencer: dispatch on command, step, conditional jump to finish
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      last_in = last_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = (req_cmd == CMD_FOLD) ? ADDR_FOLD : ADDR_SEED;
         last_in = req_last;
      end else if (run) begin
         unique case (uw.seq)
            SEQ_NEXT: step_in = step_ff + 1'b1;
            SEQ_CHK: begin
               if (last_ff) begin
                  step_in = ADDR_FIN;
               end else begin
                  busy_in = 1'b0;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= ADDR_SEED;
         last_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         last_ff <= last_in;
      end
   end

   // datapath
   assign dp_ctl = '{load: accept, run: run, uw: uw};

   mlh_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (dp_ctl),
      .atom_type          (req_atom_type),
      .child_hash         (req_child_hash),
      .invalid_hash_value (inv_ff),
      .fin_hash           (fin_hash)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (run && uw.op == OP_FIN) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = fin_hash;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_link_hash = rsp_hash_ff;

endmodule

@@ hw/rtl/mlh_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlh_dpath: running hash datapath
// Holds the running hash and a product accumulator; one 32x32 multiplier
// builds each 64-bit wrapping multiply by a mix constant from three partial products.
// ----------------------------------------------------------------------------
module mlh_dpath (
   input  logic               clock,
   input  logic               reset,
   input  mlh_pkg::dp_ctl_type ctl,
   input  logic [15:0]        atom_type,
   input  logic [63:0]        child_hash,
   input  logic [63:0]        invalid_hash_value,
   output logic [63:0]        fin_hash
);
   import mlh_pkg::*;

   logic [63:0] hash_ff, hash_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] type_ff;
   logic [63:0] child_ff;

   logic [63:0] kconst;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [31:0] upper_sum;
   logic [63:0] seed_val, mix_val, xs_val, fin_or;

   // operand selection for the shared multiplier
   always_comb begin
      kconst = (ctl.uw.ksel == KSEL_K2) ? MIX_K2 : MIX_K1;
      mul_a  = (ctl.uw.op == OP_MHB) ? hash_ff[63:32] : hash_ff[31:0];
      mul_b  = (ctl.uw.op == OP_MHA) ? kconst[63:32] : kconst[31:0];
      prod   = 64'(mul_a) * 64'(mul_b);
      upper_sum = acc_ff[63:32] + prod[31:0];
   end

   // constant-operand steps
   always_comb begin
      seed_val = 64'(64'(type_ff) * SEED_PRIME);
      mix_val  = hash_ff + ((hash_ff << 5) ^ 64'(child_ff * CHILD_MULT));
      xs_val   = hash_ff ^ (hash_ff >> MIX_SHIFT);
   end

   // next-state selection per control word
   always_comb begin
      hash_in = hash_ff;
      acc_in  = acc_ff;
      if (ctl.run) begin
         case (ctl.uw.op)
            OP_SEED: hash_in = seed_val;
            OP_MIX:  hash_in = mix_val;
            OP_XS:   hash_in = xs_val;
            OP_MLO:  acc_in  = prod;
            OP_MHA:  acc_in  = {upper_sum, acc_ff[31:0]};
            OP_MHB:  hash_in = {upper_sum, acc_ff[31:0]};
            default: ;
         endcase
      end
   end

   // running hash, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

   // accumulator and captured item fields
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.load) begin
         type_ff  <= atom_type;
         child_ff <= child_hash;
      end
   end

   // finished value: top bit set, stepped off the reserved value
   always_comb begin
      fin_or   = hash_ff | {1'b1, 63'd0};
      fin_hash = (fin_or == invalid_hash_value) ? fin_or - 64'd1 : fin_or;
   end

endmodule

@@ hw/rtl/mlh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlh_checker: port-level checks for the link hash block
// Watches the item and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module mlh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_link_hash
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_link_hash))
      else $error("stalled result changed");

   // a result has the top bit set, or is the all-ones-below value after adjust
   a_rsp_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_link_hash[63] || rsp_link_hash == 64'h7fff_ffff_ffff_ffff)
      else $error("result top bit clear");

   // an accepted item keeps the sequencer busy for the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted without busy cycle");

   // a new result only comes out of a busy sequencer
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work");

endmodule

bind merkle_link_hash mlh_checker u_mlh_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_link_hash (rsp_link_hash)
);
